FILE: rtl/core/psvf_pkg.sv
// shared types, constants and helpers for the parity split value frequency table
// no dependencies; every other file in rtl/core refers to it by scoped names
package psvf_pkg;

	// table geometry
	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int DMP_W = $clog2(2 * TABLE_DEPTH);
	localparam logic [15:0] CNT_MAX = 16'hFFFF;

	// input opcodes
	localparam logic [1:0] OP_COUNT = 2'd0;
	localparam logic [1:0] OP_DUMP  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_ACK    = 2'd0;
	localparam logic [1:0] KIND_EVEN   = 2'd1;
	localparam logic [1:0] KIND_ODD    = 2'd2;
	localparam logic [1:0] KIND_TOTALS = 2'd3;

	// input beat
	typedef struct packed {
		logic [1:0]         opcode;
		logic signed [15:0] value;
	} in_t;

	// result beat
	typedef struct packed {
		logic [1:0]         kind;
		logic signed [15:0] entry_value;
		logic [15:0]        entry_count;
		logic [15:0]        even_total;
		logic [15:0]        odd_total;
		logic               table_full;
		logic               last;
	} out_t;

	// classified command passed from front to back
	typedef enum logic [1:0] {
		CMD_COUNT = 2'd0,
		CMD_DUMP  = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_code_t;

	typedef struct packed {
		cmd_code_t   cmd;
		logic [15:0] value;
	} cmd_t;

	// handshake between the command queue and the back end
	typedef struct packed {
		logic valid;
		cmd_t head;
	} cmd_chan_t;

	// back end state machine
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_UPD  = 4'b0010,
		ST_DUMP = 4'b0100,
		ST_TOT  = 4'b1000
	} state_t;

	// saturating increment for counts and totals
	function automatic logic [15:0] sat_inc(input logic [15:0] x);
		logic [15:0] r;
		r = (x == CNT_MAX) ? CNT_MAX : x + 16'd1;
		return r;
	endfunction

endpackage

FILE: rtl/core/psvf_front.sv
// front end: takes input beats, classifies the opcode and queues commands
// depends on psvf_pkg
module psvf_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  psvf_pkg::in_t       item,
	output psvf_pkg::cmd_chan_t cmd,
	input  logic                cmd_pop
);

	psvf_pkg::cmd_t mem_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     cnt_q;
	logic           keep;
	psvf_pkg::cmd_t cls;
	logic           wr_en;
	logic           rd_en;

	// classify the opcode; the unused code is dropped here
	always_comb begin
		keep = 1'b1;
		cls.value = item.value;
		cls.cmd = psvf_pkg::CMD_COUNT;
		unique case (item.opcode)
			psvf_pkg::OP_COUNT: cls.cmd = psvf_pkg::CMD_COUNT;
			psvf_pkg::OP_DUMP:  cls.cmd = psvf_pkg::CMD_DUMP;
			psvf_pkg::OP_CLEAR: cls.cmd = psvf_pkg::CMD_CLEAR;
			default:            keep = 1'b0;
		endcase
	end

	assign full  = (cnt_q == 2'd2);
	assign wr_en = push && !full && keep;
	assign rd_en = cmd_pop && (cnt_q != 2'd0);

	assign cmd.valid = (cnt_q != 2'd0);
	assign cmd.head  = mem_q[rd_q];

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) wr_q <= ~wr_q;
			if (rd_en) rd_q <= ~rd_q;
			case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_q] <= cls;
	end

endmodule

FILE: rtl/core/psvf_back.sv
// back end: table lookup and update, dump sequencer and totals
// depends on psvf_pkg
module psvf_back (
	input  logic                clk,
	input  logic                arst_n,
	input  psvf_pkg::cmd_chan_t cmd,
	output logic                cmd_pop,
	input  logic                oq_room,
	output logic                out_push,
	output psvf_pkg::out_t      out_data
);

	localparam int D = psvf_pkg::TABLE_DEPTH;
	localparam int IW = psvf_pkg::IDX_W;
	localparam int DW = psvf_pkg::DMP_W;

	// tables, index 0 even and 1 odd
	logic [15:0]            val_q [2][D];
	logic [15:0]            cnt_q [2][D];
	logic [D-1:0]           vld_q [2];
	logic [15:0]            sum_q [2];
	psvf_pkg::state_t       state_q;
	logic [DW-1:0]          dmp_q;

	// lookup results held for the update cycle
	logic                   par_s1;
	logic [15:0]            val_s1;
	logic                   hit_s1;
	logic                   free_s1;
	logic [IW-1:0]          slot_s1;
	logic [15:0]            cnt_s1;

	logic                   par;
	logic [D-1:0]           match;
	logic                   hit_any;
	logic                   free_any;
	logic [IW-1:0]          hit_idx;
	logic [IW-1:0]          free_idx;
	logic                   dsel;
	logic [IW-1:0]          didx;
	logic                   rd_t;
	logic [IW-1:0]          rd_i;
	logic [15:0]            rd_cnt;
	logic [15:0]            new_cnt;
	logic [15:0]            new_sum;
	logic                   dmp_end;

	assign par = cmd.head.value[0];

	// parallel compare and first free slot in the table of this parity
	always_comb begin
		hit_any  = 1'b0;
		free_any = 1'b0;
		hit_idx  = '0;
		free_idx = '0;
		for (int i = 0; i < D; i++) begin
			match[i] = vld_q[par][i] && (val_q[par][i] == cmd.head.value);
		end
		for (int i = D - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_any = 1'b1;
				hit_idx = IW'(i);
			end
			if (!vld_q[par][i]) begin
				free_any = 1'b1;
				free_idx = IW'(i);
			end
		end
	end

	// dump position split into table select and entry index
	assign dsel    = (dmp_q >= DW'(D));
	assign didx    = IW'(dsel ? dmp_q - DW'(D) : dmp_q);
	assign dmp_end = (dmp_q == DW'(2 * D - 1));

	// single count read port shared by lookup and dump
	assign rd_t   = (state_q == psvf_pkg::ST_DUMP) ? dsel : par;
	assign rd_i   = (state_q == psvf_pkg::ST_DUMP) ? didx : hit_idx;
	assign rd_cnt = cnt_q[rd_t][rd_i];

	assign new_cnt = hit_s1 ? psvf_pkg::sat_inc(cnt_s1) : (free_s1 ? 16'd1 : 16'd0);
	assign new_sum = psvf_pkg::sat_inc(sum_q[par_s1]);

	// result beat and handshakes
	always_comb begin
		cmd_pop  = 1'b0;
		out_push = 1'b0;
		out_data.kind        = psvf_pkg::KIND_ACK;
		out_data.entry_value = '0;
		out_data.entry_count = '0;
		out_data.even_total  = sum_q[0];
		out_data.odd_total   = sum_q[1];
		out_data.table_full  = 1'b0;
		out_data.last        = 1'b0;
		unique case (state_q)
			psvf_pkg::ST_IDLE: begin
				cmd_pop = cmd.valid;
			end
			psvf_pkg::ST_UPD: begin
				out_push = oq_room;
				out_data.entry_value = val_s1;
				out_data.entry_count = new_cnt;
				out_data.table_full  = !hit_s1 && !free_s1;
				out_data.last        = 1'b1;
				if (par_s1) out_data.odd_total = new_sum;
				else out_data.even_total = new_sum;
			end
			psvf_pkg::ST_DUMP: begin
				out_push = oq_room && vld_q[dsel][didx];
				out_data.kind = dsel ? psvf_pkg::KIND_ODD : psvf_pkg::KIND_EVEN;
				out_data.entry_value = val_q[dsel][didx];
				out_data.entry_count = rd_cnt;
			end
			psvf_pkg::ST_TOT: begin
				out_push = oq_room;
				out_data.kind = psvf_pkg::KIND_TOTALS;
				out_data.last = 1'b1;
			end
			default: begin
				cmd_pop = 1'b0;
			end
		endcase
	end

	// sequencer, valid bits and totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psvf_pkg::ST_IDLE;
			dmp_q   <= '0;
			vld_q[0] <= '0;
			vld_q[1] <= '0;
			sum_q[0] <= '0;
			sum_q[1] <= '0;
		end else begin
			unique case (state_q)
				psvf_pkg::ST_IDLE: begin
					if (cmd.valid) begin
						case (cmd.head.cmd)
							psvf_pkg::CMD_COUNT: state_q <= psvf_pkg::ST_UPD;
							psvf_pkg::CMD_DUMP: begin
								dmp_q   <= '0;
								state_q <= psvf_pkg::ST_DUMP;
							end
							default: begin
								vld_q[0] <= '0;
								vld_q[1] <= '0;
								sum_q[0] <= '0;
								sum_q[1] <= '0;
							end
						endcase
					end
				end
				psvf_pkg::ST_UPD: begin
					if (oq_room) begin
						sum_q[par_s1] <= new_sum;
						if (!hit_s1 && free_s1) vld_q[par_s1][slot_s1] <= 1'b1;
						state_q <= psvf_pkg::ST_IDLE;
					end
				end
				psvf_pkg::ST_DUMP: begin
					if (oq_room || !vld_q[dsel][didx]) begin
						if (dmp_end) state_q <= psvf_pkg::ST_TOT;
						else dmp_q <= dmp_q + DW'(1);
					end
				end
				psvf_pkg::ST_TOT: begin
					if (oq_room) state_q <= psvf_pkg::ST_IDLE;
				end
				default: state_q <= psvf_pkg::ST_IDLE;
			endcase
		end
	end

	// lookup capture and table payload writes
	always_ff @(posedge clk) begin
		if (state_q == psvf_pkg::ST_IDLE && cmd.valid) begin
			par_s1  <= par;
			val_s1  <= cmd.head.value;
			hit_s1  <= hit_any;
			free_s1 <= free_any;
			slot_s1 <= hit_any ? hit_idx : free_idx;
			cnt_s1  <= rd_cnt;
		end
		if (state_q == psvf_pkg::ST_UPD && oq_room && (hit_s1 || free_s1)) begin
			cnt_q[par_s1][slot_s1] <= new_cnt;
			if (!hit_s1) val_q[par_s1][slot_s1] <= val_s1;
		end
	end

endmodule

FILE: rtl/core/psvf_outq.sv
// two-entry result queue between the back end and the result port
// depends on psvf_pkg
module psvf_outq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  psvf_pkg::out_t wdata,
	output logic           room,
	output logic           empty,
	input  logic           pop,
	output psvf_pkg::out_t rdata
);

	psvf_pkg::out_t mem_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     cnt_q;
	logic           wr_en;
	logic           rd_en;

	assign room  = (cnt_q != 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem_q[rd_q];
	assign wr_en = wr && room;
	assign rd_en = pop && !empty;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) wr_q <= ~wr_q;
			if (rd_en) rd_q <= ~rd_q;
			case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_q] <= wdata;
	end

endmodule

FILE: rtl/core/parity_split_value_frequency_table_core.sv
// Parity split value frequency table.
// Input side is a queue: a beat (opcode, value) is taken when push is high and
// full is low. Count beats look up the value in the even or odd table, bump or
// insert its entry and give one acknowledge result. Dump beats give one result
// per filled entry, even table first, then a totals result marked last. Clear
// beats empty both tables and zero the totals with no result; opcode three is
// dropped at the front.
// Result side is a queue: the oldest result sits on result while empty is low
// and is taken when pop is high and empty is low.
// A count beat is looked up by parallel compare in the idle state, then its
// table write and acknowledge result happen in the update state. A dump steps
// through every slot of both tables, then gives the totals result; a clear is
// done in the idle state.
// A two-entry command queue lets the front keep taking beats while the back
// end works; when the receiver stalls, the two-entry result queue fills, the
// back end holds its current step and the command queue then fills and raises
// full. Reset clears the valid bits and totals at once; no clearing pass.
// depends on psvf_pkg, psvf_front, psvf_back, psvf_outq
module parity_split_value_frequency_table_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  psvf_pkg::in_t  item,
	output logic           empty,
	input  logic           pop,
	output psvf_pkg::out_t result
);

	psvf_pkg::cmd_chan_t cmd;
	logic                cmd_pop;
	logic                oq_room;
	logic                out_push;
	psvf_pkg::out_t      out_data;

	// accept and classify
	psvf_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.cmd     (cmd),
		.cmd_pop (cmd_pop)
	);

	// table engine
	psvf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.oq_room  (oq_room),
		.out_push (out_push),
		.out_data (out_data)
	);

	// result queue
	psvf_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (out_push),
		.wdata  (out_data),
		.room   (oq_room),
		.empty  (empty),
		.pop    (pop),
		.rdata  (result)
	);

endmodule

FILE: verif/parity_split_value_frequency_table_core_tb.sv
// testbench for parity_split_value_frequency_table_core: queue handshakes on both sides,
// a scoreboard class that tracks both tables and totals and checks every result beat
// depends on psvf_pkg and the core rtl
`timescale 1ns / 100ps

module parity_split_value_frequency_table_core_tb;

	localparam int HOLD_LEN     = 300;
	localparam int RANDOM_ITEMS = 290;
	localparam logic [1:0] OP_SPARE = 2'd3;

	// tracks both tables and totals and holds the result beats still owed
	class parity_tally;
		bit [15:0]      vals   [2][psvf_pkg::TABLE_DEPTH];
		bit [15:0]      cnts   [2][psvf_pkg::TABLE_DEPTH];
		bit             used   [2][psvf_pkg::TABLE_DEPTH];
		bit [15:0]      totals [2];
		psvf_pkg::out_t owed_beats [$];
		int             mismatches;

		function new();
			wipe();
			mismatches = 0;
		endfunction

		function void wipe();
			for (int p = 0; p < 2; p++) begin
				totals[p] = '0;
				for (int i = 0; i < psvf_pkg::TABLE_DEPTH; i++) begin
					vals[p][i] = '0;
					cnts[p][i] = '0;
					used[p][i] = 1'b0;
				end
			end
		endfunction

		// saturating add of one
		function bit [15:0] bump(bit [15:0] x);
			return (&x) ? x : x + 16'd1;
		endfunction

		function void owe(logic [1:0] kind, logic [15:0] v, logic [15:0] c, logic full_flag,
				logic last_flag);
			psvf_pkg::out_t b;
			b.kind        = kind;
			b.entry_value = v;
			b.entry_count = c;
			b.even_total  = totals[0];
			b.odd_total   = totals[1];
			b.table_full  = full_flag;
			b.last        = last_flag;
			owed_beats.push_back(b);
		endfunction

		// work out the beats caused by one accepted input
		function void take_item(psvf_pkg::in_t x);
			int hit;
			int slot;
			bit p;
			case (x.opcode)
				psvf_pkg::OP_COUNT: begin
					p = x.value[0];
					hit = -1;
					slot = -1;
					totals[p] = bump(totals[p]);
					for (int i = 0; i < psvf_pkg::TABLE_DEPTH; i++) begin
						if (used[p][i]) begin
							if (hit < 0 && vals[p][i] == x.value)
								hit = i;
						end else if (slot < 0) begin
							slot = i;
						end
					end
					if (hit >= 0) begin
						cnts[p][hit] = bump(cnts[p][hit]);
						owe(psvf_pkg::KIND_ACK, x.value, cnts[p][hit], 1'b0, 1'b1);
					end else if (slot >= 0) begin
						vals[p][slot] = x.value;
						cnts[p][slot] = 16'd1;
						used[p][slot] = 1'b1;
						owe(psvf_pkg::KIND_ACK, x.value, 16'd1, 1'b0, 1'b1);
					end else begin
						// table full: value dropped, total still counts it
						owe(psvf_pkg::KIND_ACK, x.value, 16'd0, 1'b1, 1'b1);
					end
				end
				psvf_pkg::OP_DUMP: begin
					for (int q = 0; q < 2; q++)
						for (int i = 0; i < psvf_pkg::TABLE_DEPTH; i++)
							if (used[q][i])
								owe(q ? psvf_pkg::KIND_ODD : psvf_pkg::KIND_EVEN,
										vals[q][i], cnts[q][i], 1'b0, 1'b0);
					owe(psvf_pkg::KIND_TOTALS, 16'd0, 16'd0, 1'b0, 1'b1);
				end
				psvf_pkg::OP_CLEAR: begin
					wipe();
				end
				default: begin
					// opcode three is ignored
				end
			endcase
		endfunction

		function void flag(string what, logic [15:0] want, logic [15:0] got);
			mismatches++;
			$display("%0t: %s expected %h actual %h", $time, what, want, got);
		endfunction

		// compare one accepted result beat with the oldest owed beat
		function void check_beat(psvf_pkg::out_t got);
			psvf_pkg::out_t want;
			if (owed_beats.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected beat expected none actual %h", $time, got);
				return;
			end
			want = owed_beats.pop_front();
			if (got.kind !== want.kind)
				flag("kind", want.kind, got.kind);
			if (got.entry_value !== want.entry_value)
				flag("entry_value", want.entry_value, got.entry_value);
			if (got.entry_count !== want.entry_count)
				flag("entry_count", want.entry_count, got.entry_count);
			if (got.even_total !== want.even_total)
				flag("even_total", want.even_total, got.even_total);
			if (got.odd_total !== want.odd_total)
				flag("odd_total", want.odd_total, got.odd_total);
			if (got.table_full !== want.table_full)
				flag("table_full", want.table_full, got.table_full);
			if (got.last !== want.last)
				flag("last", want.last, got.last);
		endfunction

		function int pending();
			return owed_beats.size();
		endfunction
	endclass

	logic           clk;
	logic           arst_n;
	logic           push;
	logic           full;
	psvf_pkg::in_t  item;
	logic           empty;
	logic           pop;
	psvf_pkg::out_t result;

	parity_tally tally = new();
	bit          calm;
	bit          hold_req;
	bit [15:0]   pool [40];
	int          pool_n;

	parity_split_value_frequency_table_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end

	// gap length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic psvf_pkg::in_t mk_item(logic [1:0] op, logic [15:0] v);
		psvf_pkg::in_t x;
		x.opcode = op;
		x.value  = v;
		return x;
	endfunction

	function automatic void refill_pool();
		pool_n = $urandom_range(6, 40);
		foreach (pool[k])
			pool[k] = 16'($urandom);
	endfunction

	// observe accepted beats on both sides
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				tally.take_item(item);
			if (pop && !empty)
				tally.check_beat(result);
		end
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		int stall;
		stall = 0;
		pop = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				stall = HOLD_LEN;
			end
			if (stall > 0) begin
				pop <= 1'b0;
				stall--;
			end else begin
				pop <= 1'b1;
				stall = pick_gap();
			end
		end
	end

	// offer one beat and hold it until taken
	task automatic send(psvf_pkg::in_t x);
		push <= 1'b1;
		item <= x;
		do
			@(posedge clk);
		while (full);
	endtask

	// send with a random gap after it
	task automatic send_gap(psvf_pkg::in_t x);
		int gap;
		send(x);
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic psvf_pkg::in_t random_item();
		int r;
		r = $urandom_range(0, 99);
		if (r < 84)
			return mk_item(psvf_pkg::OP_COUNT, ($urandom_range(0, 9) == 0) ? 16'($urandom)
					: pool[$urandom_range(0, pool_n - 1)]);
		if (r < 94)
			return mk_item(psvf_pkg::OP_DUMP, 16'($urandom));
		if (r < 97)
			return mk_item(psvf_pkg::OP_CLEAR, 16'($urandom));
		return mk_item(OP_SPARE, 16'($urandom));
	endfunction

	// stimulus
	initial begin
		psvf_pkg::in_t x;
		int            counted;
		int            n;
		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		calm = 1'b0;
		hold_req = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty dump, extremes, zero, negative odd, ignored opcode
		send_gap(mk_item(psvf_pkg::OP_DUMP, 16'h0000));
		send_gap(mk_item(psvf_pkg::OP_COUNT, 16'h0000));
		send_gap(mk_item(psvf_pkg::OP_COUNT, 16'h0000));
		send_gap(mk_item(psvf_pkg::OP_COUNT, 16'h8000));
		send_gap(mk_item(psvf_pkg::OP_COUNT, 16'h7fff));
		send_gap(mk_item(psvf_pkg::OP_COUNT, 16'hffff));
		send_gap(mk_item(OP_SPARE, 16'h7fff));
		send_gap(mk_item(psvf_pkg::OP_DUMP, 16'hffff));
		// fill the odd table and overflow it by one
		for (int k = 1; k <= 15; k++)
			send_gap(mk_item(psvf_pkg::OP_COUNT, 16'((k * 1000) | 1)));
		send_gap(mk_item(psvf_pkg::OP_DUMP, 16'h0000));
		send_gap(mk_item(psvf_pkg::OP_CLEAR, 16'h5555));
		send_gap(mk_item(psvf_pkg::OP_DUMP, 16'haaaa));

		// random: counts from a value pool per episode, dumps, clears
		refill_pool();
		counted = 0;
		n = 0;
		while (counted < RANDOM_ITEMS) begin
			if (n % 40 == 0)
				calm = ($urandom_range(0, 3) == 0);
			if (n == 120) begin
				calm = 1'b1;
				hold_req = 1'b1;
			end
			x = (n >= 120 && n < 140)
					? mk_item(psvf_pkg::OP_COUNT, pool[$urandom_range(0, pool_n - 1)])
					: random_item();
			send_gap(x);
			if (x.opcode == psvf_pkg::OP_CLEAR)
				refill_pool();
			if (x.opcode != OP_SPARE)
				counted++;
			n++;
		end
		push <= 1'b0;

		// drain
		while (tally.pending() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (tally.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
